// ----- hw/rtl/via_pkg.sv -----
// package for the vm integer alu: operation codes, widths and payload types
// no dependencies
`default_nettype none
package via_pkg;
    localparam int unsigned WordW  = 32;
    localparam int unsigned ModeW  = 5;
    localparam int unsigned CountW = 6;

    localparam logic [ModeW-1:0] OP_ADD  = 5'd0;
    localparam logic [ModeW-1:0] OP_SUB  = 5'd1;
    localparam logic [ModeW-1:0] OP_MUL  = 5'd2;
    localparam logic [ModeW-1:0] OP_DIV  = 5'd3;
    localparam logic [ModeW-1:0] OP_MOD  = 5'd4;
    localparam logic [ModeW-1:0] OP_POW  = 5'd5;
    localparam logic [ModeW-1:0] OP_MAX  = 5'd6;
    localparam logic [ModeW-1:0] OP_MIN  = 5'd7;
    localparam logic [ModeW-1:0] OP_CLMP = 5'd8;
    localparam logic [ModeW-1:0] OP_ABS  = 5'd9;
    localparam logic [ModeW-1:0] OP_SGN  = 5'd10;
    localparam logic [ModeW-1:0] OP_LT   = 5'd11;
    localparam logic [ModeW-1:0] OP_LE   = 5'd12;
    localparam logic [ModeW-1:0] OP_NE   = 5'd13;
    localparam logic [ModeW-1:0] OP_EQ   = 5'd14;
    localparam logic [ModeW-1:0] OP_GT   = 5'd15;
    localparam logic [ModeW-1:0] OP_GE   = 5'd16;
    localparam logic [ModeW-1:0] OP_OR   = 5'd17;
    localparam logic [ModeW-1:0] OP_AND  = 5'd18;
    localparam logic [ModeW-1:0] OP_XOR  = 5'd19;
    localparam logic [ModeW-1:0] OP_SHL  = 5'd20;
    localparam logic [ModeW-1:0] OP_SHR  = 5'd21;
    localparam logic [ModeW-1:0] OP_ROTR = 5'd22;
    localparam logic [ModeW-1:0] OP_ROTL = 5'd23;
    localparam logic [ModeW-1:0] OP_LOR  = 5'd24;
    localparam logic [ModeW-1:0] OP_LAND = 5'd25;
    localparam logic [ModeW-1:0] OP_LNOT = 5'd26;

    typedef struct packed {
        logic [ModeW-1:0]        mode;
        logic signed [WordW-1:0] operand_a;
        logic signed [WordW-1:0] operand_b;
        logic signed [WordW-1:0] operand_c;
    } t_in_item;

    typedef struct packed {
        logic signed [WordW-1:0] result;
        logic                    div_by_zero;
    } t_out_item;
endpackage
`default_nettype wire

// ----- hw/rtl/via_in_if.sv -----
// valid/ready channel carrying one operation item
// depends on via_pkg
`default_nettype none
interface via_in_if;
    logic               valid;
    logic               ready;
    via_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/via_out_if.sv -----
// valid/ready channel carrying one result item
// depends on via_pkg
`default_nettype none
interface via_out_if;
    logic               valid;
    logic               ready;
    via_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/via_seq.sv -----
// sequencer: shift-add multiply and restoring divide, one bit a cycle
// depends on via_pkg
`default_nettype none
module via_seq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [via_pkg::ModeW-1:0]    i_mode,
    input  wire logic [via_pkg::WordW-1:0]    i_a,
    input  wire logic [via_pkg::WordW-1:0]    i_b,
    output logic                              o_done,
    output logic [via_pkg::WordW-1:0]         o_result
);
    import via_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CountW-1:0] r_cnt, n_cnt;
    logic [ModeW-1:0]  r_mode;
    logic [WordW-1:0]  r_x, r_y, r_acc, r_rem;
    logic              r_neg;
    logic [WordW-1:0]  ma, mb, prod, addend, rem_sh;
    logic [WordW:0]    diff;
    logic              is_div;

    assign ma = i_a[WordW-1] ? WordW'(-i_a) : i_a;
    assign mb = i_b[WordW-1] ? WordW'(-i_b) : i_b;
    assign is_div = (r_mode == OP_DIV) || (r_mode == OP_MOD);
    // shared unit: one shift-add step, or one restoring subtract step
    assign addend = r_y[0] ? r_x : '0;
    assign prod   = r_acc + addend;
    assign rem_sh = {r_rem[WordW-2:0], r_x[WordW-1]};
    assign diff   = {1'b0, rem_sh} - {1'b0, r_y};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                n_state = S_RUN;
                n_cnt   = '0;
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CountW'(WordW - 1)) n_state = S_FIX;
            end
            S_FIX: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_mode <= i_mode;
            r_acc  <= '0;
            r_rem  <= '0;
            if (i_mode == OP_DIV || i_mode == OP_MOD) begin
                r_x   <= ma;
                r_y   <= mb;
                r_neg <= (i_mode == OP_DIV) ? (i_a[WordW-1] ^ i_b[WordW-1]) : i_a[WordW-1];
            end else begin
                r_x   <= i_a;
                r_y   <= i_b;
                r_neg <= 1'b0;
            end
        end else if (r_state == S_RUN) begin
            if (is_div) begin
                r_x <= {r_x[WordW-2:0], ~diff[WordW]};
                r_rem <= diff[WordW] ? rem_sh : diff[WordW-1:0];
            end else begin
                r_acc <= prod;
                r_x   <= {r_x[WordW-2:0], 1'b0};
                r_y   <= {1'b0, r_y[WordW-1:1]};
            end
        end
    end

    assign o_done   = (r_state == S_FIX);
    always_comb begin
        if (r_mode == OP_DIV)      o_result = r_neg ? WordW'(-r_x) : r_x;
        else if (r_mode == OP_MOD) o_result = r_neg ? WordW'(-r_rem) : r_rem;
        else                       o_result = r_acc;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/vm_integer_alu_top.sv -----
// vm integer alu top: input and output channels, combinational ops, sequenced ops
// depends on via_pkg, via_in_if, via_out_if, via_seq
//
// usage: one operation item enters on i_op (valid/ready), one result item leaves on
// o_res. combinational operations (compare, logic, shift, add, sub, min, max, clamp,
// abs, sign, divide by zero, pow with a negative exponent) give their result in the
// output register in the cycle after acceptance. mul, div and mod hold the block while
// the serial sequencer runs. pow runs one round per exponent bit up to the highest set
// bit, at most 31, each a pair of serial multiplies. the block takes one item at a
// time: i_op.ready is high only while no item is in work and the output register is
// empty or being taken. a stalled receiver holds the result in the output register.
// reset empties the output register and returns the sequencer to idle.
//
`default_nettype none
module vm_integer_alu_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    via_in_if.sink    i_op,
    via_out_if.source o_res
);
    import via_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_PM1  = 3'd2;
    localparam logic [2:0] S_PW1  = 3'd3;
    localparam logic [2:0] S_PM2  = 3'd4;
    localparam logic [2:0] S_PW2  = 3'd5;

    logic [2:0]       r_state;
    logic             r_ovalid;
    t_out_item        r_out;
    logic [WordW-1:0] r_base, r_acc, r_exp;
    logic [CountW-1:0] r_round;

    logic             acc_in, seq_start, seq_done, out_set, pow_last;
    logic [ModeW-1:0] seq_mode;
    logic [WordW-1:0] seq_a, seq_b, seq_res;
    logic [WordW-1:0] a, b, c, r;
    logic [4:0]       sh;
    logic             lt_ab, lt_ba, lt_ca, slow;

    assign a  = i_op.data.operand_a;
    assign b  = i_op.data.operand_b;
    assign c  = i_op.data.operand_c;
    assign sh = b[4:0];
    assign lt_ab = $signed(a) < $signed(b);
    assign lt_ba = $signed(b) < $signed(a);
    assign lt_ca = $signed(c) < $signed(a);

    assign i_op.ready = (r_state == S_IDLE) && (!r_ovalid || o_res.ready);
    assign acc_in     = i_op.valid && i_op.ready;
    assign slow = (i_op.data.mode == OP_MUL) || (i_op.data.mode == OP_DIV && b != '0) ||
                  (i_op.data.mode == OP_MOD && b != '0) ||
                  (i_op.data.mode == OP_POW && !b[WordW-1]);
    assign pow_last = (r_round == CountW'(WordW - 1)) || (r_exp[WordW-1:1] == '0);
    assign out_set  = (acc_in && !slow) || (r_state == S_MUL && seq_done) ||
                      (r_state == S_PW2 && seq_done && pow_last);

    always_comb begin
        case (i_op.data.mode)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MAX:  r = lt_ab ? b : a;
            OP_MIN:  r = lt_ab ? a : b;
            OP_CLMP: r = lt_ab ? b : (lt_ca ? c : a);
            OP_ABS:  r = a[WordW-1] ? WordW'(-a) : a;
            OP_SGN:  r = (a == '0) ? '0 : (a[WordW-1] ? '1 : WordW'(1));
            OP_LT:   r = WordW'(lt_ab);
            OP_LE:   r = WordW'(!lt_ba);
            OP_NE:   r = WordW'(a != b);
            OP_EQ:   r = WordW'(a == b);
            OP_GT:   r = WordW'(lt_ba);
            OP_GE:   r = WordW'(!lt_ab);
            OP_OR:   r = a | b;
            OP_AND:  r = a & b;
            OP_XOR:  r = a ^ b;
            OP_SHL:  r = a << sh;
            OP_SHR:  r = a >> sh;
            OP_ROTR: r = (a >> sh) | (a << (6'd32 - {1'b0, sh}));
            OP_ROTL: r = (a << sh) | (a >> (6'd32 - {1'b0, sh}));
            OP_LOR:  r = WordW'(a != '0 || b != '0);
            OP_LAND: r = WordW'(a != '0 && b != '0);
            OP_LNOT: r = WordW'(a == '0);
            default: r = '0;
        endcase
    end

    always_comb begin
        seq_start = 1'b0;
        seq_mode  = OP_MUL;
        seq_a     = r_acc;
        seq_b     = r_base;
        if (acc_in && slow && i_op.data.mode != OP_POW) begin
            seq_start = 1'b1;
            seq_mode  = i_op.data.mode;
            seq_a     = a;
            seq_b     = b;
        end else if (r_state == S_PM1) begin
            seq_start = 1'b1;
        end else if (r_state == S_PM2) begin
            seq_start = 1'b1;
            seq_a     = r_base;
        end
    end

    via_seq u_seq (
        .i_clk, .i_rst_n,
        .i_start(seq_start), .i_mode(seq_mode), .i_a(seq_a), .i_b(seq_b),
        .o_done(seq_done), .o_result(seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (out_set) r_ovalid <= 1'b1;
            else if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (acc_in) begin
                    if (!slow) begin
                        r_out.result <= (i_op.data.mode == OP_POW) ? '0 : r;
                        r_out.div_by_zero <= (i_op.data.mode == OP_DIV ||
                                              i_op.data.mode == OP_MOD);
                    end else if (i_op.data.mode == OP_POW) begin
                        r_state <= S_PM1;
                        r_acc   <= WordW'(1);
                        r_base  <= a;
                        r_exp   <= b;
                        r_round <= '0;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: if (seq_done) begin
                    r_state <= S_IDLE;
                    r_out.result <= seq_res;
                    r_out.div_by_zero <= 1'b0;
                end
                S_PM1: r_state <= S_PW1;
                S_PW1: if (seq_done) begin
                    if (r_exp[0]) r_acc <= seq_res;
                    r_state <= S_PM2;
                end
                S_PM2: r_state <= S_PW2;
                S_PW2: if (seq_done) begin
                    r_base  <= seq_res;
                    r_exp   <= {1'b0, r_exp[WordW-1:1]};
                    r_round <= r_round + 1'b1;
                    if (pow_last) begin
                        r_state <= S_IDLE;
                        r_out.result <= r_acc;
                        r_out.div_by_zero <= 1'b0;
                    end else begin
                        r_state <= S_PM1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;
endmodule
`default_nettype wire
